@@ sv/mctt_pkg.sv @@
// Shared types, codes and constants for the multi-channel timeout timer.
// Used by mctt_cell and multi_channel_timeout_timer_core.
`default_nettype none

package mctt_pkg;

    // Default sizes
    localparam int BANK_SIZE_DEF   = 16;
    localparam int COUNT_WIDTH_DEF = 32;

    // Ids are 4 bits wide, so at most 16 timers are addressable
    localparam int ID_LIMIT = 16;

    // Configuration
    localparam int          CFG_WIDTH           = 5;
    localparam logic [4:0]  TIMERS_IN_USE_RESET = 5'd16;

    // Expiry counter saturation value
    localparam logic [15:0] EXPIRY_MAX = 16'hFFFF;

    // Input actions
    localparam logic [1:0] ACT_SET    = 2'd0;
    localparam logic [1:0] ACT_CANCEL = 2'd1;
    localparam logic [1:0] ACT_TICK   = 2'd2;

    // Result kinds
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    // Status codes
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_BAD_ID = 2'd1;
    localparam logic [1:0] STAT_IDLE   = 2'd2;

    // Input transfer payload
    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  timer_id;
        logic [31:0] timeout_ticks;
    } item_t;

    // Result transfer payload
    typedef struct packed {
        logic        result_kind;
        logic [3:0]  result_timer;
        logic [1:0]  status_code;
        logic [15:0] expiry_count;
        logic        last_result;
    } result_t;

    // Broadcast command from the controller to every cell
    typedef struct packed {
        logic set;
        logic cancel;
        logic tick;
        logic pop;
    } cell_cmd_t;

    // Per-cell status back to the controller
    typedef struct packed {
        logic armed;
        logic pend;
    } cell_stat_t;

endpackage

`default_nettype wire

@@ sv/mctt_cell.sv @@
// One timer cell: armed flag, remaining ticks, expiry count and a fired flag.
// Passes the "fired at or above" chain down to its lower neighbor.
// Depends on mctt_pkg.
`default_nettype none

module mctt_cell #(
    parameter int COUNT_WIDTH = mctt_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire mctt_pkg::cell_cmd_t   cmd,
    input  wire logic                  sel,
    input  wire logic                  en,
    input  wire logic [31:0]           timeout_ticks,
    input  wire logic                  pend_above,
    output mctt_pkg::cell_stat_t       stat,
    output logic                       pend_chain,
    output logic [15:0]                expiry_count
);
    import mctt_pkg::*;

    logic                   armed_reg, armed_next;
    logic                   pend_reg, pend_next;
    logic [COUNT_WIDTH-1:0] ticks_reg, ticks_next;
    logic [15:0]            cnt_reg, cnt_next;

    // Update the timer for set, cancel, tick and result pop
    always_comb begin
        armed_next = armed_reg;
        pend_next  = pend_reg;
        ticks_next = ticks_reg;
        cnt_next   = cnt_reg;
        if (cmd.set && sel) begin
            armed_next = 1'b1;
            ticks_next = COUNT_WIDTH'(timeout_ticks);
        end else if (cmd.cancel && sel && armed_reg) begin
            armed_next = 1'b0;
            ticks_next = '0;
            cnt_next   = '0;
        end else if (cmd.tick && en && armed_reg) begin
            if (ticks_reg <= COUNT_WIDTH'(1)) begin
                armed_next = 1'b0;
                ticks_next = '0;
                pend_next  = 1'b1;
                if (cnt_reg != EXPIRY_MAX) begin
                    cnt_next = cnt_reg + 16'd1;
                end
            end else begin
                ticks_next = ticks_reg - COUNT_WIDTH'(1);
            end
        end else if (cmd.pop && sel) begin
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg <= 1'b0;
            pend_reg  <= 1'b0;
            ticks_reg <= '0;
            cnt_reg   <= '0;
        end else begin
            armed_reg <= armed_next;
            pend_reg  <= pend_next;
            ticks_reg <= ticks_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Report state and extend the fired chain
    assign stat.armed   = armed_reg;
    assign stat.pend    = pend_reg;
    assign pend_chain   = pend_reg | pend_above;
    assign expiry_count = cnt_reg;

endmodule

`default_nettype wire

@@ sv/multi_channel_timeout_timer_core.sv @@
// Timer bank: a row of timer cells and a controller; needs mctt_pkg and mctt_cell.
// A set or cancel answer is registered in the result register once the held item
// executes; a new item is taken into the holding register only when it is empty.
// A tick updates all cells, then scans them in turn from cell 0 up to the cell above
// the highest fired id (or the last cell); a waiting result stalls either step.
// Reset (synchronous, aresetn low): timers disarmed, counts cleared, timers_in_use 16.
`default_nettype none

module multi_channel_timeout_timer_core #(
    parameter int BANK_SIZE   = mctt_pkg::BANK_SIZE_DEF,
    parameter int COUNT_WIDTH = mctt_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // input channel
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire mctt_pkg::item_t   s_data,
    // result channel
    output logic                   m_valid,
    input  wire logic              m_ready,
    output mctt_pkg::result_t      m_data,
    // configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    import mctt_pkg::*;

    localparam int IDW = (BANK_SIZE > 1) ? $clog2(BANK_SIZE) : 1;
    localparam int EFF_MAX_INT = (BANK_SIZE < ID_LIMIT) ? BANK_SIZE : ID_LIMIT;
    localparam logic [CFG_WIDTH-1:0] EFF_MAX = CFG_WIDTH'(EFF_MAX_INT);
    localparam logic [IDW-1:0] LAST_IDX = IDW'(BANK_SIZE - 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    // Configuration register
    logic [CFG_WIDTH-1:0] cfg_reg;
    logic                 cfg_wr;
    logic [CFG_WIDTH-1:0] n_eff;

    // Input holding register
    logic   in_valid_reg, in_valid_next;
    item_t  in_reg;

    // Result register
    logic    m_valid_reg, m_valid_next;
    result_t out_reg, out_next;
    logic    out_free;

    // Controller
    logic           state_reg, state_next;
    logic [IDW-1:0] scan_reg, scan_next;
    cell_cmd_t      cmd;
    logic           id_ok;
    logic           armed_sel;

    // Cell row signals
    cell_stat_t             stat_arr [BANK_SIZE];
    logic [15:0]            cnt_arr  [BANK_SIZE];
    logic [BANK_SIZE-1:0]   sel_vec;
    logic [BANK_SIZE-1:0]   en_vec;
    logic [BANK_SIZE-1:0]   armed_vec;
    logic [BANK_SIZE-1:0]   pend_vec;
    logic [BANK_SIZE-1:0]   chain_vec;
    logic [BANK_SIZE-1:0]   above_vec;

    // APB register access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : 32'(cfg_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= TIMERS_IN_USE_RESET;
        end else if (cfg_wr) begin
            cfg_reg <= pwdata[CFG_WIDTH-1:0];
        end
    end

    // Limit the enabled count to the cells present and the id range
    assign n_eff = (cfg_reg > EFF_MAX) ? EFF_MAX : cfg_reg;

    // Row of timer cells
    for (genvar i = 0; i < BANK_SIZE; i++) begin : g_cell
        localparam logic [6:0] CELL_ID = 7'(i);

        assign en_vec[i]  = CELL_ID < {2'b00, n_eff};
        assign sel_vec[i] = (state_reg == ST_SCAN) ? (scan_reg == IDW'(i))
                                                   : (CELL_ID == {3'b000, in_reg.timer_id});
        assign above_vec[i] = (i == BANK_SIZE - 1) ? 1'b0
                                                   : chain_vec[(i + 1) % BANK_SIZE];
        assign armed_vec[i] = stat_arr[i].armed;
        assign pend_vec[i]  = stat_arr[i].pend;

        mctt_cell #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .cmd           (cmd),
            .sel           (sel_vec[i]),
            .en            (en_vec[i]),
            .timeout_ticks (in_reg.timeout_ticks),
            .pend_above    (above_vec[i]),
            .stat          (stat_arr[i]),
            .pend_chain    (chain_vec[i]),
            .expiry_count  (cnt_arr[i])
        );
    end

    // Input transfer handshake
    assign s_ready = !in_valid_reg;

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    assign out_free  = !m_valid_reg || m_ready;
    assign id_ok     = {1'b0, in_reg.timer_id} < n_eff;
    assign armed_sel = id_ok && ((armed_vec >> in_reg.timer_id) & BANK_SIZE'(1)) != '0;

    // Controller: execute a held item, or scan the row for fired timers
    always_comb begin
        in_valid_next = in_valid_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        out_next      = out_reg;
        state_next    = state_reg;
        scan_next     = scan_reg;
        cmd           = '0;

        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_valid_reg && out_free) begin
                    in_valid_next         = 1'b0;
                    out_next.result_kind  = KIND_STATUS;
                    out_next.result_timer = in_reg.timer_id;
                    out_next.expiry_count = '0;
                    out_next.last_result  = 1'b1;
                    case (in_reg.action)
                        ACT_SET: begin
                            cmd.set              = id_ok;
                            m_valid_next         = 1'b1;
                            out_next.status_code = id_ok ? STAT_OK : STAT_BAD_ID;
                        end
                        ACT_CANCEL: begin
                            cmd.cancel   = armed_sel;
                            m_valid_next = 1'b1;
                            if (!id_ok) begin
                                out_next.status_code = STAT_BAD_ID;
                            end else if (!armed_sel) begin
                                out_next.status_code = STAT_IDLE;
                            end else begin
                                out_next.status_code = STAT_OK;
                            end
                        end
                        ACT_TICK: begin
                            cmd.tick   = 1'b1;
                            state_next = ST_SCAN;
                            scan_next  = '0;
                        end
                        default: begin
                            // unused action: drop
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (!chain_vec[scan_reg]) begin
                    state_next = ST_IDLE;
                end else if (!pend_vec[scan_reg] || out_free) begin
                    if (pend_vec[scan_reg]) begin
                        cmd.pop               = 1'b1;
                        m_valid_next          = 1'b1;
                        out_next.result_kind  = KIND_EXPIRY;
                        out_next.result_timer = 4'(scan_reg);
                        out_next.status_code  = STAT_OK;
                        out_next.expiry_count = cnt_arr[scan_reg];
                        out_next.last_result  = !above_vec[scan_reg];
                    end
                    // advance to the next cell
                    if (scan_reg == LAST_IDX) begin
                        state_next = ST_IDLE;
                    end else begin
                        scan_next = scan_reg + IDW'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            state_reg    <= ST_IDLE;
            scan_reg     <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            state_reg    <= state_next;
            scan_reg     <= scan_next;
        end
    end

    // Result payload needs no reset
    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench for multi_channel_timeout_timer_core: timer bank model,
// random traffic with handshake stalls, and APB writes to timers_in_use.
// Depends on mctt_pkg and the RTL of the timer bank.

module testbench;
    import mctt_pkg::*;

    localparam int          TIMER_COUNT       = BANK_SIZE_DEF;
    localparam logic [1:0]  ACT_UNUSED        = 2'd3;
    localparam logic [2:0]  REG_TIMERS_IN_USE = 3'd0;
    localparam int          SETTLE_CYCLES     = 40;
    localparam int          HOLD_OFF_CYCLES   = 300;
    localparam int          WATCHDOG_LIMIT    = 4000;
    localparam int          REPEAT_ROUNDS     = 8;
    localparam int          PHASE_ITEMS       = 82;

    // Timer bank model and store of expected results
    class timer_scoreboard;
        logic        armed [ID_LIMIT];
        logic [31:0] remaining [ID_LIMIT];
        logic [15:0] expiries [ID_LIMIT];
        logic [4:0]  timers_in_use;
        result_t     expected_results[$];
        int          error_count;

        function new();
            for (int i = 0; i < ID_LIMIT; i++) begin
                armed[i]     = 1'b0;
                remaining[i] = '0;
                expiries[i]  = '0;
            end
            timers_in_use = TIMERS_IN_USE_RESET;
            error_count   = 0;
        endfunction

        function void set_timers_in_use(logic [4:0] value);
            timers_in_use = value;
        endfunction

        function int enabled_timers();
            int n;
            n = timers_in_use;
            if (n > TIMER_COUNT) n = TIMER_COUNT;
            if (n > ID_LIMIT) n = ID_LIMIT;
            return n;
        endfunction

        function int outstanding();
            return expected_results.size();
        endfunction

        // Advance the model by one accepted transfer and queue its results
        function void note_item(item_t it);
            result_t r;
            int      n;
            int      last_fire;
            n = enabled_timers();
            r = '0;
            r.result_kind  = KIND_STATUS;
            r.result_timer = it.timer_id;
            r.last_result  = 1'b1;
            case (it.action)
                ACT_SET: begin
                    if (it.timer_id >= n) begin
                        r.status_code = STAT_BAD_ID;
                    end else begin
                        armed[it.timer_id]     = 1'b1;
                        remaining[it.timer_id] = it.timeout_ticks;
                        r.status_code = STAT_OK;
                    end
                    expected_results.push_back(r);
                end
                ACT_CANCEL: begin
                    if (it.timer_id >= n) begin
                        r.status_code = STAT_BAD_ID;
                    end else if (!armed[it.timer_id]) begin
                        r.status_code = STAT_IDLE;
                    end else begin
                        armed[it.timer_id]     = 1'b0;
                        remaining[it.timer_id] = '0;
                        expiries[it.timer_id]  = '0;
                        r.status_code = STAT_OK;
                    end
                    expected_results.push_back(r);
                end
                ACT_TICK: begin
                    // find the highest firing id so it can carry the last marker
                    last_fire = -1;
                    for (int i = 0; i < n; i++)
                        if (armed[i] && remaining[i] <= 1) last_fire = i;
                    for (int i = 0; i < n; i++) begin
                        if (!armed[i]) continue;
                        if (remaining[i] <= 1) begin
                            armed[i]     = 1'b0;
                            remaining[i] = '0;
                            if (expiries[i] != EXPIRY_MAX) expiries[i]++;
                            r = '0;
                            r.result_kind  = KIND_EXPIRY;
                            r.result_timer = i[3:0];
                            r.status_code  = STAT_OK;
                            r.expiry_count = expiries[i];
                            r.last_result  = (i == last_fire);
                            expected_results.push_back(r);
                        end else begin
                            remaining[i]--;
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function string describe(result_t r);
            return $sformatf("kind=%0d timer=%0d status=%0d count=%0d last=%0d",
                             r.result_kind, r.result_timer, r.status_code,
                             r.expiry_count, r.last_result);
        endfunction

        // Compare a result transfer with the oldest expectation
        function void check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result: %s", $time, describe(got));
                error_count++;
                return;
            end
            want = expected_results.pop_front();
            if (got !== want) begin
                $display("%0t: result mismatch: expected %s, actual %s",
                         $time, describe(want), describe(got));
                error_count++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    item_t       s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    result_t     m_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    timer_scoreboard board = new();

    bit hold_off_request = 1'b0;
    bit rx_always_ready  = 1'b0;
    bit tx_gapless       = 1'b0;
    int burst_left       = 0;
    int quiet_cycles     = 0;

    multi_channel_timeout_timer_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Check every result transfer
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_result(m_data);
    end

    // Drop the run when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: stall pattern drawn from four random modes, plus a long hold-off on request
    initial begin
        int rx_mode;
        int mode_left;
        int phase_bit;
        rx_mode   = 0;
        mode_left = 0;
        phase_bit = 0;
        forever begin
            @(posedge aclk);
            if (hold_off_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_off_request = 1'b0;
                m_ready <= 1'b1;
            end else if (rx_always_ready) begin
                m_ready <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = $urandom_range(0, 3);
                    mode_left = 64;
                end
                mode_left--;
                phase_bit = ~phase_bit;
                case (rx_mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 3) == 0);
                    2: m_ready <= ($urandom_range(0, 3) != 0);
                    default: m_ready <= phase_bit[0];
                endcase
            end
        end
    end

    function automatic item_t make_item(logic [1:0] action, logic [3:0] id,
                                        logic [31:0] ticks);
        item_t it;
        it.action        = action;
        it.timer_id      = id;
        it.timeout_ticks = ticks;
        return it;
    endfunction

    // Offer one transfer, inserting a random gap between bursts
    task automatic offer_item(input item_t it);
        int gap;
        if (!tx_gapless) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        s_data  <= it;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_item(it);
    endtask

    // Hold the input until every expected result is back, then let a scan finish
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        while (board.outstanding() > 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write timers_in_use, then read it back
    task automatic write_timers_in_use(input logic [4:0] value);
        logic [31:0] readback;
        wait_for_drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_TIMERS_IN_USE;
        pwdata  <= {27'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        board.set_timers_in_use(value);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback[4:0] !== value) begin
            $display("%0t: timers_in_use readback: expected %0d, actual %0d",
                     $time, value, readback[4:0]);
            board.error_count++;
        end
    endtask

    function automatic item_t random_item();
        item_t it;
        int    pick;
        it.timer_id      = $urandom_range(0, 15);
        it.timeout_ticks = $urandom();
        pick = $urandom_range(0, 99);
        if (pick < 38)      it.action = ACT_SET;
        else if (pick < 55) it.action = ACT_CANCEL;
        else if (pick < 95) it.action = ACT_TICK;
        else                it.action = ACT_UNUSED;
        // keep most deadlines short so ticks fire often
        if (it.action == ACT_SET) begin
            pick = $urandom_range(0, 9);
            if (pick <= 5)      it.timeout_ticks = $urandom_range(0, 6);
            else if (pick <= 7) it.timeout_ticks = $urandom_range(7, 40);
            else if (pick == 8) it.timeout_ticks = 32'hFFFF_FFFF;
        end
        return it;
    endfunction

    task automatic run_directed();
        write_timers_in_use(5'd16);
        offer_item(make_item(ACT_TICK, 4'd0, 32'd0));
        offer_item(make_item(ACT_UNUSED, 4'd15, 32'hFFFF_FFFF));
        offer_item(make_item(ACT_CANCEL, 4'd0, 32'd0));
        offer_item(make_item(ACT_SET, 4'd0, 32'd0));
        offer_item(make_item(ACT_SET, 4'd15, 32'd1));
        offer_item(make_item(ACT_SET, 4'd7, 32'hFFFF_FFFF));
        offer_item(make_item(ACT_SET, 4'd3, 32'd5));
        // rearm shortens the deadline
        offer_item(make_item(ACT_SET, 4'd3, 32'd2));
        offer_item(make_item(ACT_TICK, 4'd9, 32'hFFFF_FFFF));
        offer_item(make_item(ACT_TICK, 4'd0, 32'd0));
        offer_item(make_item(ACT_CANCEL, 4'd7, 32'd0));
        offer_item(make_item(ACT_SET, 4'd0, 32'd1));
        offer_item(make_item(ACT_TICK, 4'd0, 32'd0));
        offer_item(make_item(ACT_CANCEL, 4'd0, 32'd0));
        offer_item(make_item(ACT_SET, 4'd10, 32'd1));
        offer_item(make_item(ACT_SET, 4'd9, 32'd3));
        // lower the limit: bad ids and frozen timers
        write_timers_in_use(5'd4);
        offer_item(make_item(ACT_SET, 4'd4, 32'd1));
        offer_item(make_item(ACT_CANCEL, 4'd15, 32'd0));
        offer_item(make_item(ACT_SET, 4'd3, 32'd1));
        offer_item(make_item(ACT_TICK, 4'd0, 32'd0));
        // no timer enabled
        write_timers_in_use(5'd0);
        offer_item(make_item(ACT_SET, 4'd0, 32'd1));
        offer_item(make_item(ACT_CANCEL, 4'd0, 32'd0));
        offer_item(make_item(ACT_TICK, 4'd0, 32'd0));
        // above the bank size: all timers enabled again
        write_timers_in_use(5'd31);
        offer_item(make_item(ACT_TICK, 4'd0, 32'd0));
        offer_item(make_item(ACT_SET, 4'd12, 32'd0));
    endtask

    // Fire timer 0 repeatedly with no gaps and no receiver stalls
    task automatic run_back_to_back();
        write_timers_in_use(5'd16);
        tx_gapless      = 1'b1;
        rx_always_ready = 1'b1;
        for (int k = 0; k < REPEAT_ROUNDS; k++) begin
            offer_item(make_item(ACT_SET, 4'd0, 32'd1));
            offer_item(make_item(ACT_TICK, 4'd0, 32'd0));
        end
        offer_item(make_item(ACT_CANCEL, 4'd0, 32'd0));
        tx_gapless      = 1'b0;
        rx_always_ready = 1'b0;
    endtask

    task automatic run_random_phase(input logic [4:0] limit, input bit hold_off);
        item_t it;
        int    counted;
        write_timers_in_use(limit);
        counted = 0;
        while (counted < PHASE_ITEMS) begin
            if (hold_off && counted == 10) hold_off_request = 1'b1;
            // pause mid-phase until every expected result is back
            if (counted == PHASE_ITEMS / 2) wait_for_drain();
            it = random_item();
            offer_item(it);
            if (it.action != ACT_UNUSED) counted++;
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        run_back_to_back();
        run_random_phase(5'd16, 1'b1);
        run_random_phase(5'($urandom_range(2, 15)), 1'b0);
        run_random_phase(5'd31, 1'b0);
        run_random_phase(5'd1, 1'b0);
        run_random_phase(5'($urandom_range(0, 31)), 1'b0);
        wait_for_drain();
        if (board.error_count == 0 && board.outstanding() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/mctt_pkg.sv
sv/mctt_cell.sv
sv/multi_channel_timeout_timer_core.sv
tb/sv/testbench.sv
